// ===== sv/csvfs_pkg.sv =====
package csvfs_pkg;

   // Characters with a meaning of their own in a line.
   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] COMMA_CHAR = 8'h2c;

   // Number of entries in the queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_FIELD_END  = 2'd1,
      KIND_LINE_END   = 2'd2
   } kind_type;

   // One result item. The data fields are listed from the highest bit down,
   // so out_byte lands in the lowest bits of the packed value.
   typedef struct packed {
      kind_type    kind;
      logic [4:0]  field_count;
      logic        truncated;
      logic [8:0]  drop_count;
      logic [3:0]  field_index;
      logic [7:0]  out_byte;
   } rsp_type;

   // Everything one input item causes: one result, or two when two is set.
   typedef struct packed {
      logic     two;
      rsp_type  second;
      rsp_type  first;
   } entry_type;

endpackage

// ===== sv/csv_field_splitter_top.sv =====
// Channel  | Direction | Signals                          | Items
// ---------+-----------+----------------------------------+--------------------------------
// req      | in        | req_tvalid/tready/tdata/tlast    | one line character, or line end
// rsp      | out       | rsp_tvalid/tready/tdata/tuser    | field byte, field end, line end
//
// Cycles: an input item is taken every cycle while the queue has room; each item causes
// zero, one or two result items, and results leave one per cycle while rsp_tready is high,
// so a stream of items that each cause two results fills the queue and holds back the input.
// Reset: synchronous; afterward the parser waits at the start of a field.
// Stalls: with rsp_tready low the four-entry queue and the output register absorb
// results; req_tready falls only when the queue is full.
module csv_field_splitter_top
   import csvfs_pkg::*;
#(
   parameter int MAX_FIELDS      = 16,
   parameter int MAX_FIELD_BYTES = 511
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] in_byte
   input  logic         req_tlast,   // end_line: the item closes the line
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [7:0] out_byte, [11:8] field_index,
                                     // [20:12] drop_count, [21] truncated,
                                     // [26:22] field_count, [31:27] zero
   output logic [1:0]   rsp_tuser    // [1:0] kind: byte, field end or line end
);

   logic       queue_full;
   logic       queue_empty;
   logic       push;
   logic       pop;
   entry_type  push_entry;
   entry_type  head;
   rsp_type    rsp_item;

   // The parser classifies each character and updates the field state in the
   // cycle it is accepted; its results go into the queue as one entry.
   csvfs_front #(
      .MAX_FIELDS      (MAX_FIELDS),
      .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_byte     (req_tdata),
      .req_end_line (req_tlast),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   csvfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // The output stage splits an entry into its one or two result items.
   csvfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {5'b0, rsp_item.field_count, rsp_item.truncated,
                       rsp_item.drop_count, rsp_item.field_index, rsp_item.out_byte};
   assign rsp_tuser = rsp_item.kind;

endmodule

// ===== sv/csvfs_front.sv =====
module csvfs_front
   import csvfs_pkg::*;
#(
   parameter int MAX_FIELDS      = 16,
   parameter int MAX_FIELD_BYTES = 511
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_byte,
   input  logic        req_end_line,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   localparam int FNW = $clog2(MAX_FIELDS + 1);
   localparam int LW  = $clog2(MAX_FIELD_BYTES + 1);

   typedef enum logic [4:0] {
      MODE_START      = 5'b00001,
      MODE_PLAIN      = 5'b00010,
      MODE_QUOTED     = 5'b00100,
      MODE_QUOTE_SEEN = 5'b01000,
      MODE_DONE       = 5'b10000
   } mode_type;

   // Per-field bookkeeping.
   typedef struct packed {
      logic           lead;
      logic [LW-1:0]  len;
      logic [LW-1:0]  trail;
      logic           ovf;
   } fld_type;

   localparam fld_type FLD_CLEAR = '{lead: 1'b1, len: '0, trail: '0, ovf: 1'b0};

   mode_type        mode_ff, mode_in;
   logic [FNW-1:0]  fn_ff, fn_in;
   fld_type         fld_ff, fld_in;
   rsp_type         res [2];
   logic [1:0]      n_res;
   logic            accept;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   // True when a content byte is passed on as a field byte.
   function automatic logic emits(input fld_type f, input logic [7:0] b);
      return !(f.lead && is_ws(b)) && (f.len < LW'(MAX_FIELD_BYTES));
   endfunction

   function automatic fld_type after_content(input fld_type f, input logic [7:0] b);
      fld_type r;
      logic    ws;
      r  = f;
      ws = is_ws(b);
      if (!(f.lead && ws)) begin
         r.lead = 1'b0;
         if (f.len < LW'(MAX_FIELD_BYTES)) begin
            r.len   = LW'(f.len + 1'b1);
            r.trail = ws ? LW'(f.trail + 1'b1) : '0;
         end else if (!ws) begin
            r.ovf   = 1'b1;
            r.trail = '0;
         end
      end
      return r;
   endfunction

   function automatic rsp_type byte_rsp(input logic [FNW-1:0] fn, input logic [7:0] b);
      rsp_type r;
      r             = '0;
      r.kind        = KIND_BYTE;
      r.out_byte    = b;
      r.field_index = 4'(fn);
      return r;
   endfunction

   function automatic rsp_type end_rsp(input logic [FNW-1:0] fn, input fld_type f);
      rsp_type r;
      r             = '0;
      r.kind        = KIND_FIELD_END;
      r.field_index = 4'(fn);
      r.drop_count  = 9'(f.trail);
      r.truncated   = f.ovf;
      return r;
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      mode_in = mode_ff;
      fn_in   = fn_ff;
      fld_in  = fld_ff;
      res[0]  = '0;
      res[1]  = '0;
      n_res   = 2'd0;
      if (req_end_line) begin
         if (mode_ff == MODE_PLAIN || mode_ff == MODE_QUOTED ||
             mode_ff == MODE_QUOTE_SEEN) begin
            res[0] = end_rsp(fn_ff, fld_ff);
            n_res  = 2'd1;
            fn_in  = FNW'(fn_ff + 1'b1);
         end
         res[n_res[0]]             = '0;
         res[n_res[0]].kind        = KIND_LINE_END;
         res[n_res[0]].field_count = 5'(fn_in);
         n_res   = 2'(n_res + 1'b1);
         mode_in = MODE_START;
         fn_in   = '0;
         fld_in  = FLD_CLEAR;
      end else begin
         unique case (mode_ff)
            MODE_START: begin
               fld_in = FLD_CLEAR;
               if (req_byte == QUOTE_CHAR) begin
                  mode_in = MODE_QUOTED;
               end else if (req_byte == COMMA_CHAR) begin
                  // Empty field.
                  res[0]  = end_rsp(fn_ff, FLD_CLEAR);
                  n_res   = 2'd1;
                  fn_in   = FNW'(fn_ff + 1'b1);
                  mode_in = (fn_in >= FNW'(MAX_FIELDS)) ? MODE_DONE : MODE_START;
               end else begin
                  mode_in = MODE_PLAIN;
                  if (emits(FLD_CLEAR, req_byte)) begin
                     res[0] = byte_rsp(fn_ff, req_byte);
                     n_res  = 2'd1;
                  end
                  fld_in = after_content(FLD_CLEAR, req_byte);
               end
            end
            MODE_PLAIN: begin
               if (req_byte == COMMA_CHAR) begin
                  res[0]  = end_rsp(fn_ff, fld_ff);
                  n_res   = 2'd1;
                  fn_in   = FNW'(fn_ff + 1'b1);
                  fld_in  = FLD_CLEAR;
                  mode_in = (fn_in >= FNW'(MAX_FIELDS)) ? MODE_DONE : MODE_START;
               end else begin
                  if (emits(fld_ff, req_byte)) begin
                     res[0] = byte_rsp(fn_ff, req_byte);
                     n_res  = 2'd1;
                  end
                  fld_in = after_content(fld_ff, req_byte);
               end
            end
            MODE_QUOTED: begin
               if (req_byte == QUOTE_CHAR) begin
                  mode_in = MODE_QUOTE_SEEN;
               end else begin
                  if (emits(fld_ff, req_byte)) begin
                     res[0] = byte_rsp(fn_ff, req_byte);
                     n_res  = 2'd1;
                  end
                  fld_in = after_content(fld_ff, req_byte);
               end
            end
            MODE_QUOTE_SEEN: begin
               if (req_byte == QUOTE_CHAR) begin
                  // A doubled quote stands for one literal quote.
                  mode_in = MODE_QUOTED;
                  if (emits(fld_ff, req_byte)) begin
                     res[0] = byte_rsp(fn_ff, req_byte);
                     n_res  = 2'd1;
                  end
                  fld_in = after_content(fld_ff, req_byte);
               end else begin
                  res[0]  = end_rsp(fn_ff, fld_ff);
                  n_res   = 2'd1;
                  fn_in   = FNW'(fn_ff + 1'b1);
                  fld_in  = FLD_CLEAR;
                  mode_in = (fn_in >= FNW'(MAX_FIELDS)) ? MODE_DONE : MODE_START;
                  // Text after the closing quote opens the next field at once, unless the field limit is reached.
                  if (req_byte != COMMA_CHAR && mode_in == MODE_START) begin
                     mode_in = MODE_PLAIN;
                     if (emits(FLD_CLEAR, req_byte)) begin
                        res[1] = byte_rsp(fn_in, req_byte);
                        n_res  = 2'd2;
                     end
                     fld_in = after_content(FLD_CLEAR, req_byte);
                  end
               end
            end
            MODE_DONE: begin
               mode_in = MODE_DONE;
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase
      end
   end

   assign push              = accept && (n_res != 2'd0);
   assign push_entry.two    = n_res[1];
   assign push_entry.first  = res[0];
   assign push_entry.second = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         fn_ff   <= '0;
         fld_ff  <= FLD_CLEAR;
      end else if (accept) begin
         mode_ff <= mode_in;
         fn_ff   <= fn_in;
         fld_ff  <= fld_in;
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      fn_ff <= FNW'(MAX_FIELDS))
      else $error("field number past the field limit");
   assert property (@(posedge clock) disable iff (reset)
      (fn_ff == FNW'(MAX_FIELDS)) |-> (mode_ff == MODE_DONE))
      else $error("field limit reached but parser still active");
   assert property (@(posedge clock) disable iff (reset)
      fld_ff.trail <= fld_ff.len)
      else $error("trailing run longer than emitted field");
`endif

endmodule

// ===== sv/csvfs_queue.sv =====
module csvfs_queue
   import csvfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output entry_type  head,
   output logic       empty,
   output logic       full
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= CW'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= CW'(count_ff - 1'b1);
         end
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("queue count lost a push");
`endif

endmodule

// ===== sv/csvfs_back.sv =====
module csvfs_back
   import csvfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head,
   input  logic         empty,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_type      rsp_item
);

   logic     out_valid_ff;
   rsp_type  out_ff;
   logic     hold_valid_ff;
   rsp_type  hold_ff;
   logic     load;

   // The output register takes a new result whenever it is empty or being taken.
   assign load = !out_valid_ff || rsp_tready;
   assign pop  = load && !hold_valid_ff && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (load) begin
         if (hold_valid_ff) begin
            out_valid_ff  <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else if (!empty) begin
            out_valid_ff  <= 1'b1;
            hold_valid_ff <= head.two;
         end else begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (hold_valid_ff) begin
            out_ff <= hold_ff;
         end else if (!empty) begin
            out_ff  <= head.first;
            hold_ff <= head.second;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_item   = out_ff;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) hold_valid_ff |-> out_valid_ff)
      else $error("second result held without a first one shown");
   assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !rsp_tready) |=> hold_valid_ff)
      else $error("held second result lost during a stall");
`endif

endmodule
